### rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, codes and character classes for the DSL character tokenizer.
// ----------------------------------------------------------------------------
package dct_pkg;

  // Default widths of the position and length fields.
  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;

  // Fixed field widths.
  localparam int CHAR_W    = 21;
  localparam int KIND_W    = 5;
  localparam int PREFIX_W  = 28;
  localparam int ASCII_W   = 7;
  localparam int IN_DATA_W = 24;

  // Token queue depth; a power of two so the pointers wrap by themselves.
  localparam int FIFO_DEPTH = 4;

  // Scan modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_DONE    = 3'd4
  } mode_t;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_NUMBER  = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd1;
  localparam logic [KIND_W-1:0] K_D       = 5'd2;
  localparam logic [KIND_W-1:0] K_LAP     = 5'd3;
  localparam logic [KIND_W-1:0] K_I       = 5'd4;
  localparam logic [KIND_W-1:0] K_HBAR    = 5'd5;
  localparam logic [KIND_W-1:0] K_PSI     = 5'd6;
  localparam logic [KIND_W-1:0] K_PARTIAL = 5'd7;
  localparam logic [KIND_W-1:0] K_NABLA   = 5'd8;
  localparam logic [KIND_W-1:0] K_BRA     = 5'd9;
  localparam logic [KIND_W-1:0] K_KET     = 5'd10;
  localparam logic [KIND_W-1:0] K_ARROW   = 5'd11;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd12;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd13;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd14;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd15;
  localparam logic [KIND_W-1:0] K_EQUAL   = 5'd16;
  localparam logic [KIND_W-1:0] K_CARET   = 5'd17;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd18;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd19;
  localparam logic [KIND_W-1:0] K_LBRACK  = 5'd20;
  localparam logic [KIND_W-1:0] K_RBRACK  = 5'd21;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd22;
  localparam logic [KIND_W-1:0] K_INVALID = 5'd23;
  localparam logic [KIND_W-1:0] K_END     = 5'd24;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL     = 21'h00000;
  localparam logic [CHAR_W-1:0] CH_TAB     = 21'h00009;
  localparam logic [CHAR_W-1:0] CH_LF      = 21'h0000A;
  localparam logic [CHAR_W-1:0] CH_CR      = 21'h0000D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 21'h00020;
  localparam logic [CHAR_W-1:0] CH_HASH    = 21'h00023;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 21'h00028;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 21'h00029;
  localparam logic [CHAR_W-1:0] CH_STAR    = 21'h0002A;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 21'h0002B;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 21'h0002C;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 21'h0002D;
  localparam logic [CHAR_W-1:0] CH_DOT     = 21'h0002E;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 21'h0002F;
  localparam logic [CHAR_W-1:0] CH_0       = 21'h00030;
  localparam logic [CHAR_W-1:0] CH_9       = 21'h00039;
  localparam logic [CHAR_W-1:0] CH_EQUAL   = 21'h0003D;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 21'h00041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 21'h0005A;
  localparam logic [CHAR_W-1:0] CH_LBRACK  = 21'h0005B;
  localparam logic [CHAR_W-1:0] CH_RBRACK  = 21'h0005D;
  localparam logic [CHAR_W-1:0] CH_CARET   = 21'h0005E;
  localparam logic [CHAR_W-1:0] CH_UNDER   = 21'h0005F;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 21'h00061;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 21'h0007A;
  localparam logic [CHAR_W-1:0] CH_BAR     = 21'h0007C;
  localparam logic [CHAR_W-1:0] CH_PSI     = 21'h003C8;
  localparam logic [CHAR_W-1:0] CH_ARROW   = 21'h02192;
  localparam logic [CHAR_W-1:0] CH_PARTIAL = 21'h02202;
  localparam logic [CHAR_W-1:0] CH_NABLA   = 21'h02207;
  localparam logic [CHAR_W-1:0] CH_BRA     = 21'h027E8;

  // Keyword spellings, first character in the low bits.
  localparam logic [PREFIX_W-1:0] KW_D    = 28'h0000064;
  localparam logic [PREFIX_W-1:0] KW_I    = 28'h0000069;
  localparam logic [PREFIX_W-1:0] KW_LAP  = {7'd0, 7'h70, 7'h61, 7'h6C};
  localparam logic [PREFIX_W-1:0] KW_PSI  = {7'd0, 7'h69, 7'h73, 7'h70};
  localparam logic [PREFIX_W-1:0] KW_HBAR = {7'h72, 7'h61, 7'h62, 7'h68};

  // Push request from the lexer into the token queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // Kind of a single-character symbol; anything unknown is invalid.
  function automatic logic [KIND_W-1:0] symbol_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_PARTIAL: k = K_PARTIAL;
      CH_NABLA:   k = K_NABLA;
      CH_BRA:     k = K_BRA;
      CH_BAR:     k = K_KET;
      CH_ARROW:   k = K_ARROW;
      CH_PSI:     k = K_PSI;
      CH_PLUS:    k = K_PLUS;
      CH_MINUS:   k = K_MINUS;
      CH_STAR:    k = K_STAR;
      CH_SLASH:   k = K_SLASH;
      CH_EQUAL:   k = K_EQUAL;
      CH_CARET:   k = K_CARET;
      CH_LPAREN:  k = K_LPAREN;
      CH_RPAREN:  k = K_RPAREN;
      CH_LBRACK:  k = K_LBRACK;
      CH_RBRACK:  k = K_RBRACK;
      CH_COMMA:   k = K_COMMA;
      default:    k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

### rtl/dct_lexer.sv
// ----------------------------------------------------------------------------
// dct_lexer
// Input register and scan state; turns each character into zero, one or two
// tokens that are pushed into the token queue.
// ----------------------------------------------------------------------------
module dct_lexer
  import dct_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int TOK_W         = KIND_W + 2 * POSITION_BITS + LENGTH_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_end,
  input  logic              room,
  output push_t             push,
  output logic [TOK_W-1:0]  tok0,
  output logic [TOK_W-1:0]  tok1
);

  localparam int P = POSITION_BITS;
  localparam int L = LENGTH_BITS;

  // Input register.
  logic              v_r, v_nxt;
  logic [CHAR_W-1:0] c_r;
  logic              eoi_r;

  // Scan state.
  mode_t             mode_r, mode_nxt;
  logic              dot_r, dot_nxt;
  logic [P-1:0]      line_r, line_nxt;
  logic [P-1:0]      col_r, col_nxt;
  logic [P-1:0]      sline_r, sline_nxt;
  logic [P-1:0]      scol_r, scol_nxt;
  logic [L-1:0]      run_r, run_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;

  logic              adv;
  logic              eoi;
  logic              fall;
  logic              t0_v, t1_v;
  logic [KIND_W-1:0] t0_kind, t1_kind, id_kind;
  logic [P-1:0]      t1_line, t1_col;
  logic [L-1:0]      t1_len, run_inc;
  logic [TOK_W-1:0]  t0, t1;

  // The held item is processed once the queue has room for two tokens.
  assign adv      = v_r && room;
  assign in_ready = !v_r || room;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      c_r   <= in_char;
      eoi_r <= in_end;
    end
  end

  // Keyword match on the first characters of an identifier.
  always_comb begin
    id_kind = K_IDENT;
    if (run_r == L'(1) && prefix_r == KW_D) begin
      id_kind = K_D;
    end else if (run_r == L'(1) && prefix_r == KW_I) begin
      id_kind = K_I;
    end else if (run_r == L'(3) && prefix_r == KW_LAP) begin
      id_kind = K_LAP;
    end else if (run_r == L'(3) && prefix_r == KW_PSI) begin
      id_kind = K_PSI;
    end else if (run_r == L'(4) && prefix_r == KW_HBAR) begin
      id_kind = K_HBAR;
    end
  end

  assign run_inc = (&run_r) ? run_r : run_r + L'(1);

  // Per-character scan step.
  always_comb begin
    mode_nxt   = mode_r;
    dot_nxt    = dot_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    sline_nxt  = sline_r;
    scol_nxt   = scol_r;
    run_nxt    = run_r;
    prefix_nxt = prefix_r;
    fall       = 1'b1;
    t0_v       = 1'b0;
    t0_kind    = K_NUMBER;
    t1_v       = 1'b0;
    t1_kind    = K_END;
    t1_line    = line_r;
    t1_col     = col_r;
    t1_len     = '0;
    eoi        = eoi_r || (c_r == CH_NUL);

    // Line and column counting on the character itself.
    if (!eoi_r) begin
      if (c_r == CH_LF) begin
        if (!(&line_r)) begin
          line_nxt = line_r + P'(1);
        end
        col_nxt = '0;
      end else if (!(&col_r)) begin
        col_nxt = col_r + P'(1);
      end
    end

    // Continue or close the current run.
    unique case (mode_r)
      MODE_NUMBER: begin
        if (!eoi && (is_digit(c_r) || (c_r == CH_DOT && !dot_r))) begin
          if (c_r == CH_DOT) begin
            dot_nxt = 1'b1;
          end
          run_nxt = run_inc;
          fall    = 1'b0;
        end else begin
          t0_v     = 1'b1;
          t0_kind  = K_NUMBER;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (!eoi && (is_alpha(c_r) || is_digit(c_r))) begin
          unique case (run_r)
            L'(1):   prefix_nxt = prefix_r | {7'd0, 7'd0, c_r[ASCII_W-1:0], 7'd0};
            L'(2):   prefix_nxt = prefix_r | {7'd0, c_r[ASCII_W-1:0], 7'd0, 7'd0};
            L'(3):   prefix_nxt = prefix_r | {c_r[ASCII_W-1:0], 7'd0, 7'd0, 7'd0};
            default: prefix_nxt = prefix_r;
          endcase
          run_nxt = run_inc;
          fall    = 1'b0;
        end else begin
          t0_v     = 1'b1;
          t0_kind  = id_kind;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (!eoi) begin
          if (c_r == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
          fall = 1'b0;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_DONE: begin
        fall = 1'b0;
      end
      default: begin
      end
    endcase

    // Handle the character afresh from the idle mode.
    if (fall) begin
      t1_line = line_nxt;
      t1_col  = col_nxt;
      if (eoi) begin
        t1_v     = 1'b1;
        t1_kind  = K_END;
        t1_len   = '0;
        mode_nxt = MODE_DONE;
      end else if (is_space(c_r)) begin
        t1_v = 1'b0;
      end else if (c_r == CH_HASH) begin
        mode_nxt = MODE_COMMENT;
      end else if (is_digit(c_r) || is_alpha(c_r)) begin
        mode_nxt   = is_digit(c_r) ? MODE_NUMBER : MODE_IDENT;
        sline_nxt  = line_nxt;
        scol_nxt   = col_nxt;
        run_nxt    = L'(1);
        dot_nxt    = 1'b0;
        prefix_nxt = is_digit(c_r) ? '0 : PREFIX_W'(c_r[ASCII_W-1:0]);
      end else begin
        t1_v    = 1'b1;
        t1_kind = symbol_kind(c_r);
        t1_len  = L'(1);
      end
    end
  end

  // Token words: {last, length, column, line, kind}.
  assign t0 = {!t1_v, run_r, scol_r, sline_r, t0_kind};
  assign t1 = {1'b1, t1_len, t1_col, t1_line, t1_kind};

  // Pack the tokens so the first pushed one is always tok0.
  always_comb begin
    push.first  = adv && (t0_v || t1_v);
    push.second = adv && t0_v && t1_v;
    tok0        = t0_v ? t0 : t1;
    tok1        = t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      dot_r    <= 1'b0;
      line_r   <= P'(1);
      col_r    <= '0;
      sline_r  <= P'(1);
      scol_r   <= '0;
      run_r    <= '0;
      prefix_r <= '0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      dot_r    <= dot_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      sline_r  <= sline_nxt;
      scol_r   <= scol_nxt;
      run_r    <= run_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

### rtl/dct_token_fifo.sv
// ----------------------------------------------------------------------------
// dct_token_fifo
// Small token queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
module dct_token_fifo
  import dct_pkg::*;
#(
  parameter int TOK_W = KIND_W + 2 * POSITION_BITS_DEF + LENGTH_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  input  logic [TOK_W-1:0] tok0,
  input  logic [TOK_W-1:0] tok1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [TOK_W-1:0] out_tok
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [TOK_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_tok   = mem[rd_r];
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.first) + PTR_W'(push.second);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_r] <= tok0;
    end
    if (push.second) begin
      mem[wr_r + PTR_W'(1)] <= tok1;
    end
  end

endmodule

### rtl/dsl_character_tokenizer_core.sv
// ----------------------------------------------------------------------------
// dsl_character_tokenizer_core
// Character-stream tokenizer for a small physics DSL.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one Unicode code point per request in
//   in_tdata; in_tlast marks the end of the stream. A zero code point also
//   ends the stream. Each token leaves on the output stream with its kind,
//   line, column and length in out_tdata; out_tlast is set on the final
//   token caused by one input character.
//   An accepted character is held in the input register until the queue has
//   room for two tokens; then its tokens are registered into a four-entry
//   token queue, from which the first token is offered on the output stream.
//   One character is accepted every cycle while the queue has room for two
//   tokens; a character that yields two tokens hands them out one after the
//   other, one per output transfer.
//   After reset the scanner is idle at line 1, column 0, with an empty queue.
//   When the receiver stalls, tokens wait in the queue; in_tready drops
//   once fewer than two entries are free and a character is held. After
//   the end token every later character is taken and gives nothing.
// ----------------------------------------------------------------------------
module dsl_character_tokenizer_core
  import dct_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
  parameter int OUT_DATA_W    = ((KIND_W + 2 * POSITION_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [20:0] char_code, rest zero
  input  logic                  in_tlast,   // end_of_input
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // token_kind, token_line, token_column,
                                            // lexeme_length, then zero fill
  output logic                  out_tlast   // last_of_item
);

  localparam int TOK_W = KIND_W + 2 * POSITION_BITS + LENGTH_BITS + 1;

  push_t            push;
  logic [TOK_W-1:0] tok0, tok1, head;
  logic             room;

  // Scanner with its input register.
  dct_lexer #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .TOK_W         (TOK_W)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata[CHAR_W-1:0]),
    .in_end   (in_tlast),
    .room     (room),
    .push     (push),
    .tok0     (tok0),
    .tok1     (tok1)
  );

  // Token queue toward the receiver.
  dct_token_fifo #(
    .TOK_W (TOK_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .tok0      (tok0),
    .tok1      (tok1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  // The top bit of a token word is its last flag.
  assign out_tdata = OUT_DATA_W'(head[TOK_W-2:0]);
  assign out_tlast = head[TOK_W-1];

endmodule
